>>> hdl/cdq_pkg.sv
// Shared types, sizes and pointer helpers for the circular deque.
package cdq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FILL_W  = 4;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic load_in;
    logic execute;
    logic load_pop;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic pop_ok;
  } sts_t;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(DEPTH - 1);
    else r = p - 1'b1;
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] fill_bits(input logic [CNT_W-1:0] c);
    logic [CNT_W+FILL_W-1:0] w;
    w = {{FILL_W{1'b0}}, c};
    return w[FILL_W-1:0];
  endfunction

endpackage

>>> hdl/cdq_ram.sv
// Generic single-port-write, registered-read RAM.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cdq_ctrl.sv
// Controller state machine for the circular deque.
module cdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cdq_pkg::sts_t sts,
  output cdq_pkg::ctl_t ctl
);

  cdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl        = '0;
    unique case (state)
      cdq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load_in = 1'b1;
          state_next  = cdq_pkg::S_EXEC;
        end
      end
      cdq_pkg::S_EXEC: begin
        if (sts.out_free) begin
          ctl.execute = 1'b1;
          state_next  = sts.pop_ok ? cdq_pkg::S_READ : cdq_pkg::S_IDLE;
        end
      end
      cdq_pkg::S_READ: begin
        ctl.load_pop = 1'b1;
        state_next   = cdq_pkg::S_IDLE;
      end
      default: begin
        state_next = cdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/cdq_datapath.sv
// Pointers, count, entry RAM and output register of the circular deque.
module cdq_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  cdq_pkg::ctl_t                  ctl,
  output cdq_pkg::sts_t                  sts,
  input  logic [cdq_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [cdq_pkg::OP_W-1:0]       s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cdq_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [cdq_pkg::STAT_W-1:0]     m_tuser
);

  cdq_pkg::op_t                  op;
  logic [cdq_pkg::DATA_W-1:0]    value;
  logic [cdq_pkg::PTR_W-1:0]     head, head_next;
  logic [cdq_pkg::PTR_W-1:0]     tail, tail_next;
  logic [cdq_pkg::CNT_W-1:0]     count, count_next;
  logic                          full, empty;
  logic                          we;
  logic [cdq_pkg::PTR_W-1:0]     waddr, raddr;
  logic [cdq_pkg::DATA_W-1:0]    rdata;
  cdq_pkg::stat_t                stat;

  logic [cdq_pkg::DATA_W-1:0]    out_value;
  cdq_pkg::stat_t                out_stat;
  logic [cdq_pkg::FILL_W-1:0]    out_fill;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      op    <= cdq_pkg::op_t'(s_tuser);
      value <= s_tdata;
    end
  end

  assign full  = (count == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    we    = 1'b0;
    waddr = tail;
    raddr = tail;
    stat  = cdq_pkg::ST_DONE;
    unique case (op)
      cdq_pkg::OP_PUSH_REAR: begin
        waddr = cdq_pkg::step_up(tail);
        if (full) begin
          stat = cdq_pkg::ST_OVERFLOW;
        end else begin
          we         = 1'b1;
          tail_next  = waddr;
          count_next = count + 1'b1;
        end
      end
      cdq_pkg::OP_PUSH_FRONT: begin
        waddr = cdq_pkg::step_down(head);
        if (full) begin
          stat = cdq_pkg::ST_OVERFLOW;
        end else begin
          we         = 1'b1;
          head_next  = waddr;
          count_next = count + 1'b1;
        end
      end
      cdq_pkg::OP_POP_REAR: begin
        raddr = tail;
        if (empty) begin
          stat = cdq_pkg::ST_UNDERFLOW;
        end else begin
          tail_next  = cdq_pkg::step_down(tail);
          count_next = count - 1'b1;
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        raddr = head;
        if (empty) begin
          stat = cdq_pkg::ST_UNDERFLOW;
        end else begin
          head_next  = cdq_pkg::step_up(head);
          count_next = count - 1'b1;
        end
      end
      default: begin
        stat = cdq_pkg::ST_DONE;
      end
    endcase
  end

  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.pop_ok   = op[1] && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= cdq_pkg::PTR_W'(cdq_pkg::DEPTH - 1);
      count <= '0;
    end else if (ctl.execute) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  cdq_ram #(
    .WIDTH(cdq_pkg::DATA_W),
    .DEPTH(cdq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.execute && we),
    .waddr(waddr),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((ctl.execute && !sts.pop_ok) || ctl.load_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_pop) begin
      out_value <= rdata;
      out_stat  <= cdq_pkg::ST_DONE;
      out_fill  <= cdq_pkg::fill_bits(count);
    end else if (ctl.execute && !sts.pop_ok) begin
      out_value <= '0;
      out_stat  <= stat;
      out_fill  <= cdq_pkg::fill_bits(count_next);
    end
  end

  assign m_tdata = {{(cdq_pkg::M_DATA_W - cdq_pkg::DATA_W - cdq_pkg::FILL_W){1'b0}},
                    out_fill, out_value};
  assign m_tuser = out_stat;

endmodule

>>> hdl/circular_deque.sv
// Top level of the circular deque: controller, datapath and assertions.
// One item at a time: a push or a failed operation is accepted, then
// executed into the output register; a successful pop adds a read step
// after execution, for the registered read port of the entry RAM. A new
// item is accepted while the previous result still waits in the output
// register; execution of it waits until that register is free. Reset leaves
// the deque empty, with no clearing pass.
module circular_deque (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [cdq_pkg::S_DATA_W-1:0] s_tdata,  // push_value[31:0]
  input  logic [cdq_pkg::OP_W-1:0]     s_tuser,  // cmd[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cdq_pkg::M_DATA_W-1:0] m_tdata,  // pop_value[31:0], fill_count[35:32], zero pad
  output logic [cdq_pkg::STAT_W-1:0]   m_tuser   // status[1:0]
);

  cdq_pkg::ctl_t ctl;
  cdq_pkg::sts_t sts;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .ctl     (ctl)
  );

  cdq_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  a_exec_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.execute |-> sts.out_free)
    else $error("execute while output register busy");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |->
      $past((ctl.execute && !sts.pop_ok) || ctl.load_pop))
    else $error("result appeared without a load");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == cdq_pkg::ST_UNDERFLOW)) |-> (m_tdata[31:0] == '0))
    else $error("underflow result carries a value");
`endif

endmodule

>>> sim/tb_circular_deque.sv
// Testbench for circular_deque: directed table plus biased random traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_circular_deque;

  localparam int N_RAND     = 300;   // random items per idling phase
  localparam int HOLD_CYC   = 60;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic [cdq_pkg::DATA_W-1:0] pop_value;
    cdq_pkg::stat_t             status;
    logic [cdq_pkg::FILL_W-1:0] fill;
  } deque_result_t;

  typedef struct {
    cdq_pkg::op_t  op;
    logic [31:0]   value;
    bit            typed;
    deque_result_t want;
  } dir_row_t;

  localparam int N_DIR = 23;
  dir_row_t dir_tab [N_DIR] = '{
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_UNDERFLOW, 4'd0}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_UNDERFLOW, 4'd0}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_DONE,      4'd1}},
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, cdq_pkg::ST_DONE,      4'd0}},
    '{cdq_pkg::OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_DONE,      4'd1}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_DONE,      4'd2}},
    '{cdq_pkg::OP_PUSH_REAR,  32'h0000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_DONE,      4'd3}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_PUSH_REAR,  32'hA5A5_A5A5, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_PUSH_REAR,  32'h0000_0001, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_PUSH_REAR,  32'hDEAD_BEEF, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_OVERFLOW,  4'd8}},
    '{cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_OVERFLOW,  4'd8}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_REAR,   32'h0000_0000, 1'b0, '{32'h0, cdq_pkg::ST_DONE, 4'd0}},
    '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'h0000_0000, cdq_pkg::ST_UNDERFLOW, 4'd0}}
  };

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [cdq_pkg::S_DATA_W-1:0] s_tdata;
  logic [cdq_pkg::OP_W-1:0]     s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [cdq_pkg::M_DATA_W-1:0] m_tdata;
  logic [cdq_pkg::STAT_W-1:0]   m_tuser;

  // predictor state
  logic [cdq_pkg::DATA_W-1:0] deque_mem [cdq_pkg::DEPTH];
  int                front_pos;
  int                rear_pos;
  int                n_held;

  deque_result_t pending_results [$];
  int            n_fail;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_req;
  int            hold_left;
  int            quiet_cycles;

  circular_deque i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic deque_result_t deque_apply(input cdq_pkg::op_t op,
                                                input logic [31:0] v);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = cdq_pkg::ST_DONE;
    if (op == cdq_pkg::OP_PUSH_REAR || op == cdq_pkg::OP_PUSH_FRONT) begin
      if (n_held >= cdq_pkg::DEPTH) begin
        r.status = cdq_pkg::ST_OVERFLOW;
      end else if (op == cdq_pkg::OP_PUSH_REAR) begin
        rear_pos = (rear_pos + 1) % cdq_pkg::DEPTH;
        deque_mem[rear_pos] = v;
        n_held++;
      end else begin
        front_pos = (front_pos + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
        deque_mem[front_pos] = v;
        n_held++;
      end
    end else begin
      if (n_held == 0) begin
        r.status = cdq_pkg::ST_UNDERFLOW;
      end else if (op == cdq_pkg::OP_POP_REAR) begin
        r.pop_value = deque_mem[rear_pos];
        rear_pos = (rear_pos + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH;
        n_held--;
      end else begin
        r.pop_value = deque_mem[front_pos];
        front_pos = (front_pos + 1) % cdq_pkg::DEPTH;
        n_held--;
      end
    end
    r.fill = cdq_pkg::FILL_W'(n_held);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h8000_0000;
      3: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one item; the expectation is queued at the accepting edge
  task automatic send_item(input cdq_pkg::op_t op, input logic [31:0] v, input bit typed,
                           input deque_result_t want);
    deque_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = deque_apply(op, v);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_random(input int n_items);
    int           push_bias;
    cdq_pkg::op_t op;
    for (int i = 0; i < n_items; i++) begin
      if (i % 12 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 15;
          1: push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      if ($urandom_range(99) < push_bias) begin
        op = $urandom_range(1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
      end else begin
        op = $urandom_range(1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
      end
      send_item(op, pick_value(), 1'b0, '0);
    end
  endtask

  // receiver
  initial begin
    m_tready  <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: pop_value %h status %0d fill_count %0d",
               m_tdata[31:0], m_tuser, m_tdata[35:32]);
        n_fail++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[31:0] !== exp_r.pop_value) begin
          $error("pop_value: expected %h, got %h", exp_r.pop_value, m_tdata[31:0]);
          n_fail++;
        end
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
          n_fail++;
        end
        if (m_tdata[35:32] !== exp_r.fill) begin
          $error("fill_count: expected %0d, got %0d", exp_r.fill, m_tdata[35:32]);
          n_fail++;
        end
      end
    end
  end

  // watchdog on handshake inactivity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("circular_deque test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    n_fail        = 0;
    hold_req      = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 63;
    for (int i = 0; i < cdq_pkg::DEPTH; i++) deque_mem[i] = '0;
    front_pos = 0;
    rear_pos  = cdq_pkg::DEPTH - 1;
    n_held    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
    send_random(N_RAND);

    send_idle_pct = 63;
    recv_idle_pct = 34;
    send_random(N_RAND);

    // no idling; a long receiver stall first so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    send_random(N_RAND);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("circular_deque test passed");
    end else begin
      $display("circular_deque test failed");
    end
    $finish;
  end

endmodule
